// ===== rtl/core/sstf_disk_scheduler_macros.svh =====
// Assertion macros for the SSTF disk scheduler.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SSTF_DISK_SCHEDULER_MACROS_SVH
`define SSTF_DISK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sstf_pkg.sv =====
// Shared widths and defaults for the SSTF disk scheduler.
// No dependencies.
package sstf_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYL_W            = 16;
    localparam int DIST_W           = 16;
    localparam int TOTAL_W          = 21;
    localparam int SUM_W            = 22;
    localparam int ORDER_W          = 5;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_START_HEAD = '0;
    localparam logic [SUM_W-1:0]      TOTAL_MAX       = SUM_W'((1 << TOTAL_W) - 1);

endpackage

// ===== rtl/core/sstf_disk_scheduler.sv =====
// Shortest-seek-time-first disk scheduler top level.
// Depends on sstf_pkg, sstf_ram and sstf_disk_scheduler_macros.svh.
//
// Requests load one per cycle while busy is low; a request with last set
// closes the batch and busy rises. For a batch of n stored requests the
// block then gives n results; each result takes a full pass over the
// request RAM through its single read port (the reads, the registered
// read data, a step to close the pass and a step to commit the pick).
// Results appear on a one-cycle strobe and cannot be held off; busy falls
// in the cycle of the final strobe.
`include "sstf_disk_scheduler_macros.svh"

module sstf_disk_scheduler #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sstf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sstf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sstf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [sstf_pkg::CYL_W-1:0]      i_request_cylinder,
    input  logic                            i_last_request,
    output logic                            o_result_valid,
    output logic [sstf_pkg::CYL_W-1:0]      o_served_cylinder,
    output logic [sstf_pkg::DIST_W-1:0]     o_seek_distance,
    output logic [sstf_pkg::TOTAL_W-1:0]    o_total_seek,
    output logic [sstf_pkg::ORDER_W-1:0]    o_order_position,
    output logic                            o_batch_overflow,
    output logic                            o_last_result
);

    import sstf_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [CYL_W-1:0]        r_start_head, n_start_head;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic [MAX_REQUESTS-1:0] r_served, n_served;
    logic [CNT_W-1:0]        r_rd_idx, n_rd_idx;
    logic                    r_pend, n_pend;
    logic [IDX_W-1:0]        r_pend_idx, n_pend_idx;
    logic                    r_found, n_found;
    logic [CNT_W-1:0]        r_order, n_order;
    logic                    r_out_valid, n_out_valid;
    logic [CYL_W-1:0]        r_head, n_head;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CYL_W-1:0]        r_best_cyl, n_best_cyl;
    logic [DIST_W-1:0]       r_best_dist, n_best_dist;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [CYL_W-1:0]        r_out_cyl, n_out_cyl;
    logic [DIST_W-1:0]       r_out_dist, n_out_dist;
    logic [TOTAL_W-1:0]      r_out_total, n_out_total;
    logic [ORDER_W-1:0]      r_out_order, n_out_order;
    logic                    r_out_ovf, n_out_ovf;
    logic                    r_out_last, n_out_last;

    logic                    cfg_wr;
    logic                    accept;
    logic                    room;
    logic                    ram_we;
    logic [CYL_W-1:0]        ram_rdata;
    logic                    issue;
    logic [DIST_W-1:0]       rd_dist;
    logic [SUM_W-1:0]        sum_next;
    logic                    final_pick;

    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_START_HEAD);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_START_HEAD) ? APB_DATA_W'(r_start_head) : '0;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign room   = (r_count < CNT_W'(MAX_REQUESTS));
    assign ram_we = accept && room;
    assign issue  = (r_rd_idx < r_count);

    assign rd_dist    = (ram_rdata >= r_head) ? (ram_rdata - r_head) : (r_head - ram_rdata);
    assign sum_next   = r_sum + SUM_W'(r_best_dist);
    assign final_pick = ((r_order + CNT_W'(1)) == r_count);

    sstf_ram #(
        .WIDTH (CYL_W),
        .DEPTH (MAX_REQUESTS)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_request_cylinder),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_start_head = cfg_wr ? pwdata[CYL_W-1:0] : r_start_head;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_served     = r_served;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_rd_idx[IDX_W-1:0];
        n_found      = r_found;
        n_order      = r_order;
        n_out_valid  = 1'b0;
        n_head       = r_head;
        n_sum        = r_sum;
        n_best_cyl   = r_best_cyl;
        n_best_dist  = r_best_dist;
        n_best_idx   = r_best_idx;
        n_out_cyl    = r_out_cyl;
        n_out_dist   = r_out_dist;
        n_out_total  = r_out_total;
        n_out_order  = r_out_order;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_request) begin
                        n_state  = ST_SCAN;
                        n_served = '0;
                        n_head   = r_start_head;
                        n_sum    = '0;
                        n_order  = '0;
                        n_rd_idx = '0;
                        n_found  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                n_pend = issue;
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_pend && !r_served[r_pend_idx] && (!r_found || rd_dist < r_best_dist)) begin
                    n_found     = 1'b1;
                    n_best_cyl  = ram_rdata;
                    n_best_dist = rd_dist;
                    n_best_idx  = r_pend_idx;
                end
                if (!issue && !r_pend) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_served[r_best_idx] = 1'b1;
                n_head      = r_best_cyl;
                n_sum       = sum_next;
                n_out_valid = 1'b1;
                n_out_cyl   = r_best_cyl;
                n_out_dist  = r_best_dist;
                n_out_total = (sum_next > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                     : sum_next[TOTAL_W-1:0];
                n_out_order = ORDER_W'(r_order);
                n_out_ovf   = r_ovf;
                n_out_last  = final_pick;
                n_order     = r_order + CNT_W'(1);
                n_rd_idx    = '0;
                n_found     = 1'b0;
                if (final_pick) begin
                    n_state = ST_IDLE;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_sum   = '0;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start_head <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_served     <= '0;
            r_rd_idx     <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_order      <= '0;
            r_out_valid  <= 1'b0;
            r_head       <= '0;
            r_sum        <= '0;
        end else begin
            r_state      <= n_state;
            r_start_head <= n_start_head;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_served     <= n_served;
            r_rd_idx     <= n_rd_idx;
            r_pend       <= n_pend;
            r_found      <= n_found;
            r_order      <= n_order;
            r_out_valid  <= n_out_valid;
            r_head       <= n_head;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_best_cyl  <= n_best_cyl;
        r_best_dist <= n_best_dist;
        r_best_idx  <= n_best_idx;
        r_out_cyl   <= n_out_cyl;
        r_out_dist  <= n_out_dist;
        r_out_total <= n_out_total;
        r_out_order <= n_out_order;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_result_valid    = r_out_valid;
    assign o_served_cylinder = r_out_cyl;
    assign o_seek_distance   = r_out_dist;
    assign o_total_seek      = r_out_total;
    assign o_order_position  = r_out_order;
    assign o_batch_overflow  = r_out_ovf;
    assign o_last_result     = r_out_last;

    `SSTF_ASSERT_NEXT(a_emit_strobes, r_state == ST_EMIT, o_result_valid,
                      "pick committed without a result beat")
    `SSTF_ASSERT_NEXT(a_strobe_only_after_emit, r_state != ST_EMIT, !o_result_valid,
                      "result beat without a committed pick")
    `SSTF_ASSERT_NOW(a_emit_has_pick, r_state == ST_EMIT, r_found,
                     "commit with no unserved request found")
    `SSTF_ASSERT_NOW(a_last_beat_idle, o_result_valid && o_last_result, !busy,
                     "busy still high on final beat of batch")

endmodule

// ===== rtl/core/sstf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sstf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
